@@ rtl/ebalu_pkg.sv @@
// ----------------------------------------------------------------------------
// ebalu_pkg
// Shared opcodes and beat types for the eight-bit ALU with decimal mode.
// ----------------------------------------------------------------------------
package ebalu_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_AND = 4'd2;
  localparam logic [3:0] OP_OR  = 4'd3;
  localparam logic [3:0] OP_XOR = 4'd4;
  localparam logic [3:0] OP_CMP = 4'd5;
  localparam logic [3:0] OP_BIT = 4'd6;
  localparam logic [3:0] OP_INC = 4'd7;
  localparam logic [3:0] OP_DEC = 4'd8;
  localparam logic [3:0] OP_ASL = 4'd9;
  localparam logic [3:0] OP_LSR = 4'd10;
  localparam logic [3:0] OP_ROL = 4'd11;
  localparam logic [3:0] OP_ROR = 4'd12;
  localparam logic [3:0] OP_TSB = 4'd13;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] reg_value;
    logic [7:0] mem_value;
    logic       carry_in;
    logic       decimal_mode;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       carry_out;
    logic       zero_out;
    logic       negative_out;
    logic       overflow_out;
    logic       carry_written;
    logic       zero_written;
    logic       negative_written;
    logic       overflow_written;
  } alu_out_t;

endpackage

@@ rtl/eight_bit_alu_with_bcd.sv @@
// ----------------------------------------------------------------------------
// eight_bit_alu_with_bcd
// Eight-bit processor ALU with packed decimal add and subtract.
//
// Input beats arrive on in_valid/in_ready/in_data and carry the opcode, both
// operands, the carry flag and the decimal-mode flag. Each input beat yields
// exactly one output beat on out_valid/out_ready/out_data with the new byte,
// the four flags and a written mark for each flag.
// The datapath is a three-stage pipeline: low nibble add or subtract, then
// high nibble with decimal correction and operation select, then zero and
// negative flags into the output register. Each stage is registered, so the
// result beat leaves from the third register; throughput is one beat per
// cycle while out_ready stays high.
// When out_ready is low the stages fill and hold; in_ready drops only once
// every stage holds a beat, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages; no other state exists.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_bcd (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ebalu_pkg::alu_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ebalu_pkg::alu_out_t out_data
);

  typedef struct packed {
    ebalu_pkg::alu_in_t item;
    logic [4:0]         lo5;
  } s1_t;

  typedef struct packed {
    logic [7:0] res;
    logic       cf;
    logic       zf;
    logic       nf;
    logic       vf;
    logic       cw;
    logic       zw;
    logic       nw;
    logic       vw;
    logic       zn;
  } s2_t;

  logic                v1_r, v2_r, v3_r;
  s1_t                 s1_r, s1_nxt;
  s2_t                 s2_r, s2_nxt;
  ebalu_pkg::alu_out_t s3_r, s3_nxt;
  logic                load1, load2, load3;

  assign load3     = !v3_r || out_ready;
  assign load2     = !v2_r || load3;
  assign load1     = !v1_r || load2;
  assign in_ready  = load1;
  assign out_valid = v3_r;
  assign out_data  = s3_r;

  always_comb begin
    s1_nxt.item = in_data;
    if (in_data.opcode == ebalu_pkg::OP_SUB) begin
      s1_nxt.lo5 = {1'b0, in_data.reg_value[3:0]} - {1'b0, in_data.mem_value[3:0]}
                   - {4'd0, !in_data.carry_in};
    end else begin
      s1_nxt.lo5 = {1'b0, in_data.reg_value[3:0]} + {1'b0, in_data.mem_value[3:0]}
                   + {4'd0, in_data.carry_in};
    end
  end

  logic [7:0] a2, m2;
  logic       c2, d2;
  logic       lo_cy, lo_fix, hi_fix;
  logic [3:0] lo_nib, hi_nib;
  logic [4:0] hi5;
  logic [8:0] cmp9;
  logic [7:0] arith;

  always_comb begin
    a2 = s1_r.item.reg_value;
    m2 = s1_r.item.mem_value;
    c2 = s1_r.item.carry_in;
    d2 = s1_r.item.decimal_mode;
    lo_cy  = 1'b0;
    lo_fix = 1'b0;
    hi_fix = 1'b0;
    lo_nib = s1_r.lo5[3:0];
    hi5    = 5'd0;
    hi_nib = 4'd0;
    if (s1_r.item.opcode == ebalu_pkg::OP_SUB) begin
      lo_cy  = s1_r.lo5[4];
      lo_fix = d2 && lo_cy;
      lo_nib = lo_fix ? s1_r.lo5[3:0] - 4'd6 : s1_r.lo5[3:0];
      hi5    = {1'b0, a2[7:4]} - {1'b0, m2[7:4]} - {4'd0, lo_cy};
      hi_fix = d2 && hi5[4];
      hi_nib = hi_fix ? hi5[3:0] - 4'd6 : hi5[3:0];
    end else begin
      lo_fix = d2 && (s1_r.lo5 > 5'd9);
      lo_cy  = d2 ? lo_fix : s1_r.lo5[4];
      lo_nib = lo_fix ? s1_r.lo5[3:0] + 4'd6 : s1_r.lo5[3:0];
      hi5    = {1'b0, a2[7:4]} + {1'b0, m2[7:4]} + {4'd0, lo_cy};
      hi_fix = d2 && (hi5 > 5'd9);
      hi_nib = hi_fix ? hi5[3:0] + 4'd6 : hi5[3:0];
    end
    arith = {hi_nib, lo_nib};
    cmp9  = {1'b0, a2} - {1'b0, m2};

    s2_nxt = '0;
    s2_nxt.res = a2;
    case (s1_r.item.opcode)
      ebalu_pkg::OP_ADD: begin
        s2_nxt.res = arith;
        s2_nxt.cf  = d2 ? hi_fix : hi5[4];
        s2_nxt.cw  = 1'b1;
        s2_nxt.vf  = !d2 && ((a2[7] ^ arith[7]) & (m2[7] ^ arith[7]));
        s2_nxt.vw  = !d2;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_SUB: begin
        s2_nxt.res = arith;
        s2_nxt.cf  = !hi5[4];
        s2_nxt.cw  = 1'b1;
        s2_nxt.vf  = !d2 && ((a2[7] ^ arith[7]) & (a2[7] ^ m2[7]));
        s2_nxt.vw  = !d2;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_AND: begin
        s2_nxt.res = a2 & m2;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_OR: begin
        s2_nxt.res = a2 | m2;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_XOR: begin
        s2_nxt.res = a2 ^ m2;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_CMP: begin
        s2_nxt.cf = !cmp9[8];
        s2_nxt.cw = 1'b1;
        s2_nxt.zf = (cmp9[7:0] == 8'd0);
        s2_nxt.nf = cmp9[7];
        s2_nxt.zw = 1'b1;
        s2_nxt.nw = 1'b1;
      end
      ebalu_pkg::OP_BIT: begin
        s2_nxt.zf = ((a2 & m2) == 8'd0);
        s2_nxt.nf = m2[7];
        s2_nxt.vf = m2[6];
        s2_nxt.zw = 1'b1;
        s2_nxt.nw = 1'b1;
        s2_nxt.vw = 1'b1;
      end
      ebalu_pkg::OP_INC: begin
        s2_nxt.res = m2 + 8'd1;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_DEC: begin
        s2_nxt.res = m2 - 8'd1;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_ASL: begin
        s2_nxt.res = {m2[6:0], 1'b0};
        s2_nxt.cf  = m2[7];
        s2_nxt.cw  = 1'b1;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_LSR: begin
        s2_nxt.res = {1'b0, m2[7:1]};
        s2_nxt.cf  = m2[0];
        s2_nxt.cw  = 1'b1;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_ROL: begin
        s2_nxt.res = {m2[6:0], c2};
        s2_nxt.cf  = m2[7];
        s2_nxt.cw  = 1'b1;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_ROR: begin
        s2_nxt.res = {c2, m2[7:1]};
        s2_nxt.cf  = m2[0];
        s2_nxt.cw  = 1'b1;
        s2_nxt.zn  = 1'b1;
      end
      ebalu_pkg::OP_TSB: begin
        s2_nxt.res = m2 | a2;
        s2_nxt.zf  = ((a2 & m2) == 8'd0);
        s2_nxt.zw  = 1'b1;
      end
      default: begin
        s2_nxt.res = a2;
      end
    endcase
  end

  always_comb begin
    s3_nxt.result           = s2_r.res;
    s3_nxt.carry_out        = s2_r.cf;
    s3_nxt.zero_out         = s2_r.zn ? (s2_r.res == 8'd0) : s2_r.zf;
    s3_nxt.negative_out     = s2_r.zn ? s2_r.res[7] : s2_r.nf;
    s3_nxt.overflow_out     = s2_r.vf;
    s3_nxt.carry_written    = s2_r.cw;
    s3_nxt.zero_written     = s2_r.zn || s2_r.zw;
    s3_nxt.negative_written = s2_r.zn || s2_r.nw;
    s3_nxt.overflow_written = s2_r.vw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (load1) begin
        v1_r <= in_valid;
      end
      if (load2) begin
        v2_r <= v1_r;
      end
      if (load3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_r <= s1_nxt;
    end
    if (load2) begin
      s2_r <= s2_nxt;
    end
    if (load3) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the eight-bit ALU with decimal mode against its own prediction of
// every operation. Each input beat is predicted when it is accepted, and each
// result beat is compared field by field, in order. A short directed set
// covers every opcode, the operand extremes and the decimal corner cases.
// Random beats follow, with random idling on both sides and one long output
// hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_BEATS = 1400;
  localparam int TAIL_BEATS   = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT_BEAT = 300;
  localparam int HOLD_CYCLES  = 120;

  class alu_scoreboard;
    ebalu_pkg::alu_out_t expected_results[$];
    int                  errors;

    function new();
      errors = 0;
    endfunction

    function ebalu_pkg::alu_out_t predict_alu(ebalu_pkg::alu_in_t x);
      ebalu_pkg::alu_out_t y;
      logic [7:0]          a;
      logic [7:0]          m;
      logic [7:0]          r;
      logic [7:0]          t;
      logic [8:0]          s;
      logic                zn;
      int                  lo;
      int                  hi;
      int                  borrow;
      y      = '0;
      a      = x.reg_value;
      m      = x.mem_value;
      r      = a;
      zn     = 1'b0;
      borrow = x.carry_in ? 0 : 1;
      case (x.opcode)
        ebalu_pkg::OP_ADD: begin
          if (x.decimal_mode) begin
            lo = int'(a[3:0]) + int'(m[3:0]) + int'(x.carry_in);
            hi = int'(a[7:4]) + int'(m[7:4]);
            if (lo > 9) begin
              lo += 6;
              hi += 1;
            end
            if (hi > 9) hi += 6;
            r           = {hi[3:0], lo[3:0]};
            y.carry_out = (hi > 15);
          end else begin
            s                  = {1'b0, a} + {1'b0, m} + {8'd0, x.carry_in};
            r                  = s[7:0];
            y.carry_out        = s[8];
            y.overflow_out     = ((a ^ r) & (m ^ r) & 8'h80) != 8'h00;
            y.overflow_written = 1'b1;
          end
          y.carry_written = 1'b1;
          zn              = 1'b1;
        end
        ebalu_pkg::OP_SUB: begin
          if (x.decimal_mode) begin
            lo = int'(a[3:0]) - int'(m[3:0]) - borrow;
            hi = int'(a[7:4]) - int'(m[7:4]);
            if (lo < 0) begin
              lo -= 6;
              hi -= 1;
            end
            if (hi < 0) hi -= 6;
            r = {hi[3:0], lo[3:0]};
          end else begin
            r                  = a - m - 8'(borrow);
            y.overflow_out     = ((a ^ r) & (a ^ m) & 8'h80) != 8'h00;
            y.overflow_written = 1'b1;
          end
          y.carry_out     = int'(a) >= int'(m) + borrow;
          y.carry_written = 1'b1;
          zn              = 1'b1;
        end
        ebalu_pkg::OP_AND: begin
          r  = a & m;
          zn = 1'b1;
        end
        ebalu_pkg::OP_OR: begin
          r  = a | m;
          zn = 1'b1;
        end
        ebalu_pkg::OP_XOR: begin
          r  = a ^ m;
          zn = 1'b1;
        end
        ebalu_pkg::OP_CMP: begin
          t                  = a - m;
          y.carry_out        = a >= m;
          y.zero_out         = t == 8'h00;
          y.negative_out     = t[7];
          y.carry_written    = 1'b1;
          y.zero_written     = 1'b1;
          y.negative_written = 1'b1;
        end
        ebalu_pkg::OP_BIT: begin
          y.zero_out         = (a & m) == 8'h00;
          y.negative_out     = m[7];
          y.overflow_out     = m[6];
          y.zero_written     = 1'b1;
          y.negative_written = 1'b1;
          y.overflow_written = 1'b1;
        end
        ebalu_pkg::OP_INC: begin
          r  = m + 8'h01;
          zn = 1'b1;
        end
        ebalu_pkg::OP_DEC: begin
          r  = m - 8'h01;
          zn = 1'b1;
        end
        ebalu_pkg::OP_ASL: begin
          y.carry_out     = m[7];
          y.carry_written = 1'b1;
          r               = {m[6:0], 1'b0};
          zn              = 1'b1;
        end
        ebalu_pkg::OP_LSR: begin
          y.carry_out     = m[0];
          y.carry_written = 1'b1;
          r               = {1'b0, m[7:1]};
          zn              = 1'b1;
        end
        ebalu_pkg::OP_ROL: begin
          y.carry_out     = m[7];
          y.carry_written = 1'b1;
          r               = {m[6:0], x.carry_in};
          zn              = 1'b1;
        end
        ebalu_pkg::OP_ROR: begin
          y.carry_out     = m[0];
          y.carry_written = 1'b1;
          r               = {x.carry_in, m[7:1]};
          zn              = 1'b1;
        end
        ebalu_pkg::OP_TSB: begin
          y.zero_out     = (a & m) == 8'h00;
          y.zero_written = 1'b1;
          r              = m | a;
        end
        default: r = a;
      endcase
      if (zn) begin
        y.zero_out         = r == 8'h00;
        y.negative_out     = r[7];
        y.zero_written     = 1'b1;
        y.negative_written = 1'b1;
      end
      y.result = r;
      return y;
    endfunction

    function void note_input(ebalu_pkg::alu_in_t x);
      expected_results.push_back(predict_alu(x));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ebalu_pkg::alu_out_t got);
      ebalu_pkg::alu_out_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("carry_out", 8'(want.carry_out), 8'(got.carry_out));
      compare_field("zero_out", 8'(want.zero_out), 8'(got.zero_out));
      compare_field("negative_out", 8'(want.negative_out), 8'(got.negative_out));
      compare_field("overflow_out", 8'(want.overflow_out), 8'(got.overflow_out));
      compare_field("carry_written", 8'(want.carry_written), 8'(got.carry_written));
      compare_field("zero_written", 8'(want.zero_written), 8'(got.zero_written));
      compare_field("negative_written", 8'(want.negative_written),
                    8'(got.negative_written));
      compare_field("overflow_written", 8'(want.overflow_written),
                    8'(got.overflow_written));
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ebalu_pkg::alu_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ebalu_pkg::alu_out_t out_data;

  alu_scoreboard sb = new();
  int            beats_in    = 0;
  int            cycles      = 0;
  bit            tail_phase  = 1'b0;
  bit            hold_done   = 1'b0;

  eight_bit_alu_with_bcd DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
        beats_in++;
      end
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_beat(ebalu_pkg::alu_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_op(logic [3:0] op, logic [7:0] a, logic [7:0] m, logic c, logic d);
    ebalu_pkg::alu_in_t item;
    item.opcode       = op;
    item.reg_value    = a;
    item.mem_value    = m;
    item.carry_in     = c;
    item.decimal_mode = d;
    send_beat(item);
  endtask

  task automatic pause_input();
    if (!tail_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      3, 4:    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int op = 0; op < 16; op++) begin
      if (op % 2 == 0) send_op(4'(op), 8'hFF, 8'h00, 1'b1, 1'b1);
      else             send_op(4'(op), 8'h00, 8'hFF, 1'b0, 1'b0);
    end
    send_op(ebalu_pkg::OP_ADD, 8'h99, 8'h01, 1'b0, 1'b1);
    send_op(ebalu_pkg::OP_ADD, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_op(ebalu_pkg::OP_SUB, 8'h00, 8'h01, 1'b1, 1'b1);
    send_op(ebalu_pkg::OP_SUB, 8'h00, 8'h00, 1'b0, 1'b1);
    send_op(ebalu_pkg::OP_ADD, 8'h7F, 8'h01, 1'b0, 1'b0);
    send_op(ebalu_pkg::OP_SUB, 8'h80, 8'h01, 1'b1, 1'b0);
    send_op(ebalu_pkg::OP_CMP, 8'h42, 8'h42, 1'b0, 1'b1);
    send_op(ebalu_pkg::OP_BIT, 8'h0F, 8'hC0, 1'b1, 1'b0);
    send_op(ebalu_pkg::OP_TSB, 8'hAA, 8'h55, 1'b0, 1'b0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      ebalu_pkg::alu_in_t item;
      if (i >= RANDOM_BEATS - TAIL_BEATS) tail_phase = 1'b1;
      item.opcode       = 4'($urandom_range(0, 15));
      item.reg_value    = pick_byte();
      item.mem_value    = pick_byte();
      item.carry_in     = 1'($urandom_range(0, 1));
      item.decimal_mode = 1'($urandom_range(0, 1));
      send_beat(item);
      pause_input();
    end
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
